### rtl/tcw_pkg.sv
// Shared constants for the text console writer: geometry defaults, field widths, codes and attributes.
package tcw_pkg;

  // Default screen geometry and tab stop spacing
  localparam int unsigned ColumnsDef  = 80;
  localparam int unsigned RowsDef     = 25;
  localparam int unsigned TabWidthDef = 4;

  // Field widths fixed by the port list
  localparam int unsigned FuncW   = 2;
  localparam int unsigned CharW   = 8;
  localparam int unsigned ColorW  = 8;
  localparam int unsigned IndexW  = 11;
  localparam int unsigned CellW   = CharW + ColorW;

  // Operation codes
  localparam logic [FuncW-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FuncW-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FuncW-1:0] FUNC_READ  = 2'd2;

  // Control characters
  localparam logic [CharW-1:0] CHR_SPACE = 8'h20;
  localparam logic [CharW-1:0] CHR_NL    = 8'h0A;
  localparam logic [CharW-1:0] CHR_CR    = 8'h0D;
  localparam logic [CharW-1:0] CHR_BS    = 8'h08;
  localparam logic [CharW-1:0] CHR_TAB   = 8'h09;

  // Attributes
  localparam logic [ColorW-1:0] BLANK_ATTR  = 8'h0F;
  localparam logic [ColorW-1:0] COLOR_RESET = 8'h07;

endpackage

### rtl/tcw_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
module tcw_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2000,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/text_console_writer_unit.sv
// Text console writer: cell store, cursor tracking, scrolling, clear and cell read.
//
//  channel   | signals                                         | handshake
//  ----------+-------------------------------------------------+---------------------------
//  request   | func_i, char_code_i, cell_index_i               | start high, busy low
//  result    | cursor_position_o, cell_char_o, cell_color_o    | done_o, one cycle, no stall
//  config    | text_color_wdata_i                              | text_color_we_i
//
// A request's result strobes on the following cycle or later. Plain characters, newline,
// carriage return and backspace strobe done_o in the cycle after acceptance unless they
// scroll; a valid read strobes from ST_READ. A tab writes one cell per cycle, up to TabWidth
// cells, then strobes. A scroll walks the cell RAM through its single read and write port,
// copying each row up one row, then blanking the last row. Clear writes one cell per cycle
// over all cells. Reset clears cursor and control state, sets color to COLOR_RESET; cell
// contents are undefined until written. The receiver cannot stall.
module text_console_writer_unit
  import tcw_pkg::*;
#(
  parameter int unsigned Columns  = ColumnsDef,
  parameter int unsigned Rows     = RowsDef,
  parameter int unsigned TabWidth = TabWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [FuncW-1:0]  func_i,
  input  logic [CharW-1:0]  char_code_i,
  input  logic [IndexW-1:0] cell_index_i,
  input  logic              text_color_we_i,
  input  logic [ColorW-1:0] text_color_wdata_i,
  output logic              done_o,
  output logic [IndexW-1:0] cursor_position_o,
  output logic [CharW-1:0]  cell_char_o,
  output logic [ColorW-1:0] cell_color_o
);

  localparam int unsigned CellCount = Columns * Rows;
  localparam int unsigned LastStart = (Rows - 1) * Columns;
  localparam int unsigned AW        = $clog2(CellCount);
  localparam int unsigned CLW       = $clog2(Columns);
  localparam int unsigned PW        = (TabWidth > 1) ? $clog2(TabWidth) : 1;
  localparam int unsigned CmpW      = ((AW > IndexW) ? AW : IndexW) + 1;

  localparam logic [AW-1:0]   COLS_A     = AW'(Columns);
  localparam logic [AW-1:0]   LAST_A     = AW'(LastStart);
  localparam logic [AW-1:0]   CELLS_M1_A = AW'(CellCount - 1);
  localparam logic [CLW-1:0]  COL_MAX    = CLW'(Columns - 1);
  localparam logic [PW-1:0]   PH_MAX     = PW'(TabWidth - 1);
  localparam logic [PW-1:0]   PH_COL_MAX = PW'((Columns - 1) % TabWidth);
  localparam logic [CmpW-1:0] CELLS_CMP  = CmpW'(CellCount);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAB,
    ST_COPY,
    ST_BLANK,
    ST_CLEAR,
    ST_READ
  } state_e;

  state_e              state_q;
  logic [AW-1:0]       cursor_q;
  logic [AW-1:0]       row_q;     // cell index of column 0 of the cursor row
  logic [CLW-1:0]      col_q;
  logic [PW-1:0]       phase_q;   // column modulo tab width
  logic [AW-1:0]       cnt_q;
  logic [CharW-1:0]    fill_q;
  logic [ColorW-1:0]   color_q;
  logic                done_q;
  logic [CharW-1:0]    res_char_q;
  logic [ColorW-1:0]   res_color_q;

  logic                accept;
  logic                read_ok;
  logic                col_last;
  logic [AW-1:0]       adv_cursor;
  logic [CLW-1:0]      adv_col;
  logic [PW-1:0]       adv_phase;
  logic [AW-1:0]       adv_row;
  logic                adv_scroll;
  logic [AW-1:0]       nl_row;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [CellW-1:0]    ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [CellW-1:0]    ram_rdata;

  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  assign read_ok = (CmpW'(cell_index_i) < CELLS_CMP);

  // Cursor one cell ahead, with row wrap and tab phase
  always_comb begin
    col_last   = (col_q == COL_MAX);
    adv_cursor = cursor_q + AW'(1);
    adv_col    = col_last ? '0 : col_q + CLW'(1);
    adv_phase  = (col_last || phase_q == PH_MAX) ? '0 : phase_q + PW'(1);
    adv_row    = col_last ? row_q + COLS_A : row_q;
    adv_scroll = (adv_cursor == LAST_A);
    nl_row     = row_q + COLS_A;
  end

  // Cell RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cursor_q;
    ram_wdata = {CHR_SPACE, color_q};
    ram_raddr = AW'(cell_index_i);
    case (state_q)
      ST_IDLE: begin
        if (accept && func_i == FUNC_PUT) begin
          case (char_code_i)
            CHR_NL, CHR_CR, CHR_TAB: ram_we = 1'b0;
            CHR_BS: begin
              ram_we    = (cursor_q != '0);
              ram_waddr = cursor_q - AW'(1);
            end
            default: begin
              ram_we    = 1'b1;
              ram_wdata = {char_code_i, color_q};
            end
          endcase
        end
      end
      ST_TAB: ram_we = 1'b1;
      ST_COPY: begin
        // read one row ahead, write back the previous read one cell behind
        ram_raddr = cnt_q + COLS_A;
        ram_we    = (cnt_q != '0);
        ram_waddr = cnt_q - AW'(1);
        ram_wdata = ram_rdata;
      end
      ST_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = {CHR_SPACE, BLANK_ATTR};
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = {fill_q, color_q};
      end
      default: ram_we = 1'b0;
    endcase
  end

  tcw_ram #(
    .Width (CellW),
    .Depth (CellCount)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer, cursor and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cursor_q    <= '0;
      row_q       <= '0;
      col_q       <= '0;
      phase_q     <= '0;
      cnt_q       <= '0;
      fill_q      <= '0;
      color_q     <= COLOR_RESET;
      done_q      <= 1'b0;
      res_char_q  <= '0;
      res_color_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (text_color_we_i) begin
        color_q <= text_color_wdata_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            res_char_q  <= '0;
            res_color_q <= '0;
            case (func_i)
              FUNC_PUT: begin
                case (char_code_i)
                  CHR_NL: begin
                    cursor_q <= nl_row;
                    row_q    <= nl_row;
                    col_q    <= '0;
                    phase_q  <= '0;
                    if (nl_row == LAST_A) begin
                      cnt_q   <= '0;
                      state_q <= ST_COPY;
                    end else begin
                      done_q <= 1'b1;
                    end
                  end
                  CHR_CR: begin
                    cursor_q <= row_q;
                    col_q    <= '0;
                    phase_q  <= '0;
                    done_q   <= 1'b1;
                  end
                  CHR_BS: begin
                    if (cursor_q != '0) begin
                      cursor_q <= cursor_q - AW'(1);
                      if (col_q == '0) begin
                        col_q   <= COL_MAX;
                        phase_q <= PH_COL_MAX;
                        row_q   <= row_q - COLS_A;
                      end else begin
                        col_q   <= col_q - CLW'(1);
                        phase_q <= (phase_q == '0) ? PH_MAX : phase_q - PW'(1);
                      end
                    end
                    done_q <= 1'b1;
                  end
                  CHR_TAB: state_q <= ST_TAB;
                  default: begin
                    cursor_q <= adv_cursor;
                    col_q    <= adv_col;
                    phase_q  <= adv_phase;
                    row_q    <= adv_row;
                    if (adv_scroll) begin
                      cnt_q   <= '0;
                      state_q <= ST_COPY;
                    end else begin
                      done_q <= 1'b1;
                    end
                  end
                endcase
              end
              FUNC_CLEAR: begin
                fill_q  <= char_code_i;
                cnt_q   <= '0;
                state_q <= ST_CLEAR;
              end
              FUNC_READ: begin
                if (read_ok) begin
                  state_q <= ST_READ;
                end else begin
                  done_q <= 1'b1;
                end
              end
              default: done_q <= 1'b1;
            endcase
          end
        end
        ST_TAB: begin
          // one space per cycle until the next tab stop or row end
          cursor_q <= adv_cursor;
          col_q    <= adv_col;
          phase_q  <= adv_phase;
          row_q    <= adv_row;
          if (adv_scroll) begin
            cnt_q   <= '0;
            state_q <= ST_COPY;
          end else if (adv_phase == '0) begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        ST_COPY: begin
          if (cnt_q == LAST_A) begin
            state_q <= ST_BLANK;
          end else begin
            cnt_q <= cnt_q + AW'(1);
          end
        end
        ST_BLANK: begin
          if (cnt_q == CELLS_M1_A) begin
            cursor_q <= cursor_q - COLS_A;
            row_q    <= row_q - COLS_A;
            done_q   <= 1'b1;
            state_q  <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + AW'(1);
          end
        end
        ST_CLEAR: begin
          if (cnt_q == CELLS_M1_A) begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + AW'(1);
          end
        end
        ST_READ: begin
          res_char_q  <= ram_rdata[CellW-1 -: CharW];
          res_color_q <= ram_rdata[ColorW-1:0];
          done_q      <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o            = done_q;
  assign cursor_position_o = IndexW'(cursor_q);
  assign cell_char_o       = res_char_q;
  assign cell_color_o      = res_color_q;

endmodule
